// ----- design/dsps_pkg.sv -----
// Package for the dual servo PWM scaler: command codes, register map,
// reset values and the scaling / midpoint helpers.
// No dependencies.
package dsps_pkg;

  typedef enum logic [2:0] {
    FUNC_TICK      = 3'd0,
    FUNC_INIT      = 3'd1,
    FUNC_SET_SCALE = 3'd2,
    FUNC_SET_RAW   = 3'd3,
    FUNC_GET       = 3'd4,
    FUNC_CAL_LOW   = 3'd5,
    FUNC_CAL_HIGH  = 3'd6,
    FUNC_DISABLE   = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    SERVO_PITCH = 2'd0,
    SERVO_YAW   = 2'd1,
    SERVO_NONE2 = 2'd2,
    SERVO_NONE3 = 2'd3
  } servo_t;

  typedef enum logic [2:0] {
    REG_PERIOD_TOP = 3'd0,
    REG_YAW_MIN    = 3'd1,
    REG_YAW_MAX    = 3'd2,
    REG_PITCH_MIN  = 3'd3,
    REG_PITCH_MAX  = 3'd4
  } reg_idx_t;

  localparam logic [15:0] PERIOD_TOP_RST = 16'd40000;
  localparam logic [15:0] MIN_INIT_RST   = 16'd2000;
  localparam logic [15:0] MAX_INIT_RST   = 16'd4000;
  localparam logic [15:0] BAD_ID_VALUE   = 16'hFFFF;
  localparam logic [7:0]  FULL_SCALE     = 8'hFF;

  // lo + (hi - lo) / 2 with the signed difference truncated toward zero
  function automatic logic [15:0] midpoint(input logic [15:0] lo, input logic [15:0] hi);
    logic [15:0] up;
    logic [15:0] dn;
    up = hi - lo;
    dn = lo - hi;
    if (hi >= lo) return lo + {1'b0, up[15:1]};
    else return lo - {1'b0, dn[15:1]};
  endfunction

  // lo + ((hi - lo) mod 2^16) * pos / 255, mod 2^16
  // x / 255 is taken as (x + x/256 + x/65536) / 256, which is low by at most
  // one, then fixed by a single remainder compare.
  function automatic logic [15:0] scale_pos(input logic [15:0] lo, input logic [15:0] hi,
                                            input logic [7:0] pos);
    logic [15:0] range;
    logic [23:0] prod;
    logic [24:0] sum;
    logic [16:0] quo;
    logic [24:0] rem;
    range = hi - lo;
    prod  = range * pos;
    sum   = {1'b0, prod} + {9'd0, prod[23:8]} + {17'd0, prod[23:16]};
    quo   = sum[24:8];
    rem   = {1'b0, prod} - (({8'd0, quo} << 8) - {8'd0, quo});
    if (rem >= {17'd0, FULL_SCALE}) quo = quo + 17'd1;
    return lo + quo[15:0];
  endfunction

endpackage

// ----- design/dual_servo_pwm_scaler.sv -----
// Dual servo PWM scaler: yaw / pitch PWM levels driven by command requests.
// A request is processed once it sits in the input register; its result is then written
// to the result register and m_tvalid rises, unless a waiting result holds the input register.
// Throughput: one request per cycle while m_tready is high; if a result waits,
// the input register takes one more request and then s_tready drops.
// Reset (rst, sync): config to defaults, state cleared, counter stopped, pins floated.
module dual_servo_pwm_scaler
  import dsps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // position[7:0], raw_width[23:8]
  input  logic [4:0]  s_tuser,   // func[2:0], servo[4:3]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // yaw_pin[0], pitch_pin[1], pins_driven[2],
                                 // read_data[18:3], zero[23:19]
);

  // config registers
  logic [15:0] period_top, yaw_min_init, yaw_max_init, pitch_min_init, pitch_max_init;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      period_top     <= PERIOD_TOP_RST;
      yaw_min_init   <= MIN_INIT_RST;
      yaw_max_init   <= MAX_INIT_RST;
      pitch_min_init <= MIN_INIT_RST;
      pitch_max_init <= MAX_INIT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PERIOD_TOP: period_top     <= pwdata[15:0];
        REG_YAW_MIN:    yaw_min_init   <= pwdata[15:0];
        REG_YAW_MAX:    yaw_max_init   <= pwdata[15:0];
        REG_PITCH_MIN:  pitch_min_init <= pwdata[15:0];
        REG_PITCH_MAX:  pitch_max_init <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_PERIOD_TOP: prdata = {16'd0, period_top};
      REG_YAW_MIN:    prdata = {16'd0, yaw_min_init};
      REG_YAW_MAX:    prdata = {16'd0, yaw_max_init};
      REG_PITCH_MIN:  prdata = {16'd0, pitch_min_init};
      REG_PITCH_MAX:  prdata = {16'd0, pitch_max_init};
      default:        prdata = 32'd0;
    endcase
  end

  // input register
  logic        in_valid;
  func_t       in_func;
  servo_t      in_servo;
  logic [7:0]  in_pos;
  logic [15:0] in_raw;
  logic        adv;

  assign adv      = in_valid & (~m_tvalid | m_tready);
  assign s_tready = ~in_valid | adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_func  <= func_t'(s_tuser[2:0]);
      in_servo <= servo_t'(s_tuser[4:3]);
      in_pos   <= s_tdata[7:0];
      in_raw   <= s_tdata[23:8];
    end
  end

  // block state
  logic [15:0] frame_count, yaw_active, pitch_active, yaw_pending, pitch_pending;
  logic [15:0] yaw_low_limit, yaw_high_limit, pitch_low_limit, pitch_high_limit;
  logic        counting, driving;

  logic [15:0] frame_count_next, yaw_active_next, pitch_active_next;
  logic [15:0] yaw_pending_next, pitch_pending_next;
  logic [15:0] yaw_low_limit_next, yaw_high_limit_next;
  logic [15:0] pitch_low_limit_next, pitch_high_limit_next;
  logic        counting_next, driving_next;
  logic [15:0] rd_next;
  logic [15:0] scaled_lo, scaled_hi, scaled;

  // one scaler shared by both channels
  assign scaled_lo = (in_servo == SERVO_YAW) ? yaw_low_limit  : pitch_low_limit;
  assign scaled_hi = (in_servo == SERVO_YAW) ? yaw_high_limit : pitch_high_limit;
  assign scaled    = scale_pos(scaled_lo, scaled_hi, in_pos);

  always_comb begin
    frame_count_next      = frame_count;
    yaw_active_next       = yaw_active;
    pitch_active_next     = pitch_active;
    yaw_pending_next      = yaw_pending;
    pitch_pending_next    = pitch_pending;
    yaw_low_limit_next    = yaw_low_limit;
    yaw_high_limit_next   = yaw_high_limit;
    pitch_low_limit_next  = pitch_low_limit;
    pitch_high_limit_next = pitch_high_limit;
    counting_next         = counting;
    driving_next          = driving;
    rd_next               = 16'd0;
    unique case (in_func)
      FUNC_TICK: begin
        if (counting) begin
          if (frame_count >= period_top) begin
            frame_count_next  = 16'd0;
            yaw_active_next   = yaw_pending;
            pitch_active_next = pitch_pending;
          end else begin
            frame_count_next = frame_count + 16'd1;
          end
        end
      end
      FUNC_INIT: begin
        counting_next         = 1'b1;
        driving_next          = 1'b1;
        yaw_low_limit_next    = yaw_min_init;
        yaw_high_limit_next   = yaw_max_init;
        pitch_low_limit_next  = pitch_min_init;
        pitch_high_limit_next = pitch_max_init;
        yaw_pending_next      = midpoint(yaw_min_init, yaw_max_init);
        pitch_pending_next    = midpoint(pitch_min_init, pitch_max_init);
      end
      FUNC_SET_SCALE: begin
        if (in_servo == SERVO_PITCH) pitch_pending_next = scaled;
        else if (in_servo == SERVO_YAW) yaw_pending_next = scaled;
      end
      FUNC_SET_RAW: begin
        if (in_servo == SERVO_PITCH) pitch_pending_next = in_raw;
        else if (in_servo == SERVO_YAW) yaw_pending_next = in_raw;
      end
      FUNC_GET: begin
        if (in_servo == SERVO_PITCH) rd_next = pitch_active;
        else if (in_servo == SERVO_YAW) rd_next = yaw_active;
        else rd_next = BAD_ID_VALUE;
      end
      FUNC_CAL_LOW: begin
        // clamp so the low limit never passes the high one
        yaw_low_limit_next   = (yaw_active > yaw_high_limit) ? yaw_high_limit : yaw_active;
        pitch_low_limit_next = (pitch_active > pitch_high_limit) ? pitch_high_limit
                                                                 : pitch_active;
      end
      FUNC_CAL_HIGH: begin
        yaw_high_limit_next   = (yaw_active < yaw_low_limit) ? yaw_low_limit : yaw_active;
        pitch_high_limit_next = (pitch_active < pitch_low_limit) ? pitch_low_limit
                                                                 : pitch_active;
      end
      FUNC_DISABLE: begin
        counting_next = 1'b0;
        driving_next  = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count      <= 16'd0;
      yaw_active       <= 16'd0;
      pitch_active     <= 16'd0;
      yaw_pending      <= 16'd0;
      pitch_pending    <= 16'd0;
      yaw_low_limit    <= 16'd0;
      yaw_high_limit   <= 16'd0;
      pitch_low_limit  <= 16'd0;
      pitch_high_limit <= 16'd0;
      counting         <= 1'b0;
      driving          <= 1'b0;
    end else if (adv) begin
      frame_count      <= frame_count_next;
      yaw_active       <= yaw_active_next;
      pitch_active     <= pitch_active_next;
      yaw_pending      <= yaw_pending_next;
      pitch_pending    <= pitch_pending_next;
      yaw_low_limit    <= yaw_low_limit_next;
      yaw_high_limit   <= yaw_high_limit_next;
      pitch_low_limit  <= pitch_low_limit_next;
      pitch_high_limit <= pitch_high_limit_next;
      counting         <= counting_next;
      driving          <= driving_next;
    end
  end

  // result register; pin levels come from the updated state
  logic yaw_pin_next, pitch_pin_next;

  assign yaw_pin_next   = driving_next & (frame_count_next < yaw_active_next);
  assign pitch_pin_next = driving_next & ~(frame_count_next < pitch_active_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {5'd0, rd_next, driving_next, pitch_pin_next, yaw_pin_next};
    end
  end

endmodule

// ----- dv/tb_dual_servo_pwm_scaler.sv -----
// Testbench for dual_servo_pwm_scaler: random and directed command requests with a
// cycle-free PWM predictor, checked field by field on the result stream.
// Depends on dsps_pkg and the dual_servo_pwm_scaler RTL.
`timescale 1ns / 100ps

module tb_dual_servo_pwm_scaler;
  import dsps_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int LONG_HOLD  = 60;

  typedef struct {
    func_t       func;
    servo_t      servo;
    logic [7:0]  position;
    logic [15:0] raw_width;
  } servo_req_t;

  typedef struct {
    logic        yaw_pin;
    logic        pitch_pin;
    logic        driven;
    logic [15:0] read_data;
  } pin_levels_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // position[7:0], raw_width[23:8]
  logic [4:0]  s_tuser = '0;   // func[2:0], servo[4:3]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // yaw_pin[0], pitch_pin[1], pins_driven[2],
                               // read_data[18:3], zero[23:19]

  dual_servo_pwm_scaler u_top (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // predictor state
  logic [15:0] cfg_reg [5];
  logic [15:0] frame_cnt, yaw_act, pitch_act, yaw_buf, pitch_buf;
  logic [15:0] yaw_lo, yaw_hi, pitch_lo, pitch_hi;
  logic        run_cnt, drive_pins;

  servo_req_t  pending_reqs [$];
  pin_levels_t expected_levels [$];
  servo_req_t  req_cur;
  int          reqs_queued = 0;
  int          reqs_taken = 0;
  int          mismatch_count = 0;
  int          tx_gap_max = 0;
  int          rx_gap_max = 0;
  int          tx_gap_left;
  int          rx_wait;
  int          idle_cycles;
  logic        rx_hold_req = 1'b0;
  logic        rx_hold_seen;

  // min + signed (max - min) / 2, truncated toward zero
  function automatic logic [15:0] mid16(input logic [15:0] lo, input logic [15:0] hi);
    int diff;
    diff = int'(hi) - int'(lo);
    return 16'(int'(lo) + diff / 2);
  endfunction

  function automatic logic [15:0] scaled16(input logic [15:0] lo, input logic [15:0] hi,
                                           input logic [7:0] pos);
    logic [15:0] span;
    logic [31:0] prod;
    span = hi - lo;
    prod = span * pos;
    return lo + 16'(prod / {24'd0, FULL_SCALE});
  endfunction

  task automatic advance_pwm(input servo_req_t r);
    pin_levels_t o;
    logic [15:0] rd;
    rd = '0;
    case (r.func)
      FUNC_TICK: begin
        if (run_cnt) begin
          if (frame_cnt >= cfg_reg[REG_PERIOD_TOP]) begin
            frame_cnt = '0;
            yaw_act   = yaw_buf;
            pitch_act = pitch_buf;
          end else begin
            frame_cnt = frame_cnt + 16'd1;
          end
        end
      end
      FUNC_INIT: begin
        run_cnt    = 1'b1;
        drive_pins = 1'b1;
        yaw_lo     = cfg_reg[REG_YAW_MIN];
        yaw_hi     = cfg_reg[REG_YAW_MAX];
        pitch_lo   = cfg_reg[REG_PITCH_MIN];
        pitch_hi   = cfg_reg[REG_PITCH_MAX];
        yaw_buf    = mid16(yaw_lo, yaw_hi);
        pitch_buf  = mid16(pitch_lo, pitch_hi);
      end
      FUNC_SET_SCALE: begin
        if (r.servo == SERVO_PITCH) pitch_buf = scaled16(pitch_lo, pitch_hi, r.position);
        else if (r.servo == SERVO_YAW) yaw_buf = scaled16(yaw_lo, yaw_hi, r.position);
      end
      FUNC_SET_RAW: begin
        if (r.servo == SERVO_PITCH) pitch_buf = r.raw_width;
        else if (r.servo == SERVO_YAW) yaw_buf = r.raw_width;
      end
      FUNC_GET: begin
        if (r.servo == SERVO_PITCH) rd = pitch_act;
        else if (r.servo == SERVO_YAW) rd = yaw_act;
        else rd = BAD_ID_VALUE;
      end
      FUNC_CAL_LOW: begin
        // clamp so the low limit never passes the high one
        yaw_lo   = (yaw_act > yaw_hi) ? yaw_hi : yaw_act;
        pitch_lo = (pitch_act > pitch_hi) ? pitch_hi : pitch_act;
      end
      FUNC_CAL_HIGH: begin
        yaw_hi   = (yaw_act < yaw_lo) ? yaw_lo : yaw_act;
        pitch_hi = (pitch_act < pitch_lo) ? pitch_lo : pitch_act;
      end
      default: begin
        run_cnt    = 1'b0;
        drive_pins = 1'b0;
      end
    endcase
    o.yaw_pin   = drive_pins && (frame_cnt < yaw_act);
    o.pitch_pin = drive_pins && !(frame_cnt < pitch_act);
    o.driven    = drive_pins;
    o.read_data = rd;
    expected_levels.push_back(o);
  endtask

  task automatic report_field(input string fname, input logic [15:0] want,
                              input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, fname, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_result(input logic [23:0] word);
    pin_levels_t want;
    if (expected_levels.size() == 0) begin
      $display("%0t: unexpected result, expected none, got %h", $time, word);
      mismatch_count++;
    end else begin
      want = expected_levels.pop_front();
      report_field("yaw_pin", {15'd0, want.yaw_pin}, {15'd0, word[0]});
      report_field("pitch_pin", {15'd0, want.pitch_pin}, {15'd0, word[1]});
      report_field("pins_driven", {15'd0, want.driven}, {15'd0, word[2]});
      report_field("read_data", want.read_data, word[18:3]);
      report_field("pad", 16'd0, {11'd0, word[23:19]});
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid    <= 1'b0;
      tx_gap_left <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        advance_pwm(req_cur);
        reqs_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_gap_left != 0) begin
          tx_gap_left <= tx_gap_left - 1;
          s_tvalid    <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          req_cur = pending_reqs.pop_front();
          s_tdata     <= {req_cur.raw_width, req_cur.position};
          s_tuser     <= {req_cur.servo, req_cur.func};
          s_tvalid    <= 1'b1;
          tx_gap_left <= $urandom_range(0, tx_gap_max);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure; a toggle of rx_hold_req starts a long stall
  always @(posedge clk) begin
    int unsigned rx_draw;
    if (rst) begin
      m_tready     <= 1'b0;
      rx_wait      <= 0;
      rx_hold_seen <= rx_hold_req;
    end else begin
      if (m_tvalid && m_tready) check_result(m_tdata);
      if (rx_hold_seen != rx_hold_req) begin
        rx_hold_seen <= rx_hold_req;
        rx_wait      <= LONG_HOLD;
        m_tready     <= 1'b0;
      end else if (rx_wait != 0) begin
        rx_wait  <= rx_wait - 1;
        m_tready <= (rx_wait == 1);
      end else if (m_tvalid && m_tready) begin
        rx_draw = $urandom_range(0, rx_gap_max);
        rx_wait  <= rx_draw;
        m_tready <= (rx_draw == 0);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[dual_servo_pwm_scaler] ERROR");
        $finish;
      end
    end
  end

  task automatic cfg_write(input reg_idx_t idx, input logic [15:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_reg[idx] = val;
  endtask

  task automatic queue_req(input func_t f, input servo_t s, input logic [7:0] p,
                           input logic [15:0] w);
    servo_req_t r;
    r.func      = f;
    r.servo     = s;
    r.position  = p;
    r.raw_width = w;
    pending_reqs.push_back(r);
    reqs_queued++;
  endtask

  task automatic wait_drained();
    while (reqs_taken != reqs_queued || expected_levels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // mostly ticks so frames wrap; compare values often land inside the frame
  task automatic queue_random_req(input logic [15:0] top);
    int unsigned pick;
    servo_t      sv;
    logic [7:0]  pos;
    logic [15:0] raw;
    func_t       f;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) sv = servo_t'($urandom_range(2, 3));
    else sv = servo_t'($urandom_range(0, 1));
    if ($urandom_range(0, 3) == 0) pos = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    else pos = 8'($urandom);
    if ($urandom_range(0, 1) == 0) raw = 16'($urandom);
    else raw = 16'($urandom_range(0, int'(top) + 2));
    if (pick < 55) f = FUNC_TICK;
    else if (pick < 60) f = FUNC_INIT;
    else if (pick < 72) f = FUNC_SET_SCALE;
    else if (pick < 80) f = FUNC_SET_RAW;
    else if (pick < 88) f = FUNC_GET;
    else if (pick < 92) f = FUNC_CAL_LOW;
    else if (pick < 96) f = FUNC_CAL_HIGH;
    else f = FUNC_DISABLE;
    queue_req(f, sv, pos, raw);
  endtask

  task automatic run_phase(input logic [15:0] top, input logic [15:0] ymin,
                           input logic [15:0] ymax, input logic [15:0] pmin,
                           input logic [15:0] pmax, input int count, input int txg,
                           input int rxg, input bit hold);
    cfg_write(REG_PERIOD_TOP, top);
    cfg_write(REG_YAW_MIN, ymin);
    cfg_write(REG_YAW_MAX, ymax);
    cfg_write(REG_PITCH_MIN, pmin);
    cfg_write(REG_PITCH_MAX, pmax);
    tx_gap_max = txg;
    rx_gap_max = rxg;
    queue_req(FUNC_INIT, SERVO_PITCH, 8'h00, 16'h0000);
    for (int i = 0; i < count; i++) queue_random_req(top);
    if (hold) begin
      @(posedge clk);
      rx_hold_req <= ~rx_hold_req;
    end
    wait_drained();
  endtask

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    cfg_reg[REG_PERIOD_TOP] = PERIOD_TOP_RST;
    cfg_reg[REG_YAW_MIN]    = MIN_INIT_RST;
    cfg_reg[REG_YAW_MAX]    = MAX_INIT_RST;
    cfg_reg[REG_PITCH_MIN]  = MIN_INIT_RST;
    cfg_reg[REG_PITCH_MAX]  = MAX_INIT_RST;
    {frame_cnt, yaw_act, pitch_act, yaw_buf, pitch_buf} = '0;
    {yaw_lo, yaw_hi, pitch_lo, pitch_hi} = '0;
    run_cnt    = 1'b0;
    drive_pins = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: commands before init, scaling ends, bad ids, wrap, calibration, disable
    cfg_write(REG_PERIOD_TOP, 16'd4);
    queue_req(FUNC_TICK, SERVO_PITCH, 8'h00, 16'h0000);
    queue_req(FUNC_GET, SERVO_PITCH, 8'h00, 16'h0000);
    queue_req(FUNC_GET, SERVO_NONE3, 8'h00, 16'h0000);
    queue_req(FUNC_SET_RAW, SERVO_YAW, 8'h00, 16'hFFFF);
    queue_req(FUNC_SET_SCALE, SERVO_PITCH, 8'hFF, 16'h0000);
    queue_req(FUNC_INIT, SERVO_YAW, 8'h00, 16'h0000);
    queue_req(FUNC_SET_SCALE, SERVO_YAW, 8'h00, 16'h0000);
    queue_req(FUNC_SET_SCALE, SERVO_YAW, 8'hFF, 16'h0000);
    queue_req(FUNC_SET_SCALE, SERVO_PITCH, 8'h80, 16'h0000);
    queue_req(FUNC_SET_SCALE, SERVO_NONE2, 8'hC8, 16'h0000);
    queue_req(FUNC_SET_RAW, SERVO_NONE3, 8'h00, 16'h1234);
    queue_req(FUNC_SET_RAW, SERVO_PITCH, 8'h00, 16'd2);
    queue_req(FUNC_SET_RAW, SERVO_YAW, 8'h00, 16'd3);
    repeat (6) queue_req(FUNC_TICK, SERVO_YAW, 8'h00, 16'h0000);
    queue_req(FUNC_GET, SERVO_YAW, 8'h00, 16'h0000);
    queue_req(FUNC_GET, SERVO_PITCH, 8'h00, 16'h0000);
    queue_req(FUNC_GET, SERVO_NONE2, 8'h00, 16'h0000);
    queue_req(FUNC_CAL_LOW, SERVO_PITCH, 8'h00, 16'h0000);
    queue_req(FUNC_CAL_HIGH, SERVO_PITCH, 8'h00, 16'h0000);
    queue_req(FUNC_DISABLE, SERVO_PITCH, 8'h00, 16'h0000);
    queue_req(FUNC_TICK, SERVO_PITCH, 8'h00, 16'h0000);
    queue_req(FUNC_INIT, SERVO_PITCH, 8'h00, 16'h0000);
    wait_drained();

    // shortest frame, full-range and inverted limits, no idling on either side
    run_phase(16'd1, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 150, 0, 0, 1'b0);
    // longest frame, degenerate limits
    run_phase(16'hFFFF, 16'd100, 16'd100, 16'd0, 16'd0, 60, 8, 8, 1'b0);
    // long receiver stall fills the block and blocks the request side
    run_phase(16'd7, 16'd3, 16'd9, 16'd9, 16'd3, 180, 8, 8, 1'b1);
    run_phase(16'd20, 16'hFFFF, 16'd0, 16'd5, 16'd65530, 180, 8, 0, 1'b0);
    run_phase(16'd12, 16'($urandom), 16'($urandom), 16'($urandom_range(0, 14)),
              16'($urandom_range(0, 14)), 180, 0, 8, 1'b0);

    repeat (8) @(posedge clk);
    if (mismatch_count == 0) $display("[dual_servo_pwm_scaler] OK");
    else $display("[dual_servo_pwm_scaler] ERROR");
    $finish;
  end

endmodule
